[hw/rtl/lsom_pkg.sv]
// Shared types, widths, codes and the arctangent table of the scan occupancy marker.
package lsom_pkg;

  // Cell store: 15-bit cell index.
  localparam int CELL_STORE = 32768;
  localparam int ADDR_W     = 15;

  // Scan tag kept per cell; tag 0 never matches a live scan.
  localparam int EPOCH_W = 8;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 16;
  localparam int XY_W         = 33;
  localparam int Z_W          = 34;
  localparam int ATAN_W       = 31;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

  // Shared multiplier operands and product.
  localparam int MA_W = 18;
  localparam int MB_W = 34;
  localparam int MP_W = MA_W + MB_W;

  // Cell coordinate width (signed).
  localparam int CW = 22;

  // Command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Register indexes.
  localparam logic [2:0] REG_RANGE_MIN   = 3'd0;
  localparam logic [2:0] REG_RANGE_MAX   = 3'd1;
  localparam logic [2:0] REG_ANGLE_START = 3'd2;
  localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [2:0] REG_CELLS_PER_M = 3'd4;

  typedef enum logic [1:0] {
    ST_MARK    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef struct packed {
    logic                   done;
    logic signed [XY_W-1:0] cos_v;
    logic signed [XY_W-1:0] sin_v;
  } cordic_res_t;

  // Arctangent of 2^-i, 2^32 units per turn.
  function automatic logic [ATAN_W-1:0] atan_lookup(input logic [3:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      4'd0:    v = 31'd536870912;
      4'd1:    v = 31'd316933406;
      4'd2:    v = 31'd167458907;
      4'd3:    v = 31'd85004756;
      4'd4:    v = 31'd42667331;
      4'd5:    v = 31'd21354465;
      4'd6:    v = 31'd10679838;
      4'd7:    v = 31'd5340245;
      4'd8:    v = 31'd2670163;
      4'd9:    v = 31'd1335087;
      4'd10:   v = 31'd667544;
      4'd11:   v = 31'd333772;
      4'd12:   v = 31'd166886;
      4'd13:   v = 31'd83443;
      4'd14:   v = 31'd41722;
      4'd15:   v = 31'd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/lsom_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lsom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/lsom_mul.sv]
// Shared signed multiplier with registered product.
module lsom_mul import lsom_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] a,
  input  logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

[hw/rtl/lsom_cordic.sv]
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos and sin in Q30.
module lsom_cordic import lsom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] theta,
  output cordic_res_t res
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic signed [XY_W-1:0] x, y;
  logic signed [Z_W-1:0]  z;
  logic                   flip;
  logic [CNT_W-1:0]       cnt;
  logic                   busy, done;

  logic signed [16:0]     ang, ang_f;
  logic                   flip_in;
  logic signed [Z_W-1:0]  z0;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;

  // Fold into +-quarter turn; results negated on a fold.
  always_comb begin
    ang = {theta[15], theta};
    if (ang > 17'sd16384) begin
      ang_f   = ang - 17'sd32768;
      flip_in = 1'b1;
    end else if (ang < -17'sd16384) begin
      ang_f   = ang + 17'sd32768;
      flip_in = 1'b1;
    end else begin
      ang_f   = ang;
      flip_in = 1'b0;
    end
    z0 = {{(Z_W-33){ang_f[16]}}, ang_f, 16'b0};
    dx = y >>> cnt;
    dy = x >>> cnt;
    da = $signed({{(Z_W-ATAN_W){1'b0}}, atan_lookup(4'(cnt))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_X0;
      y    <= '0;
      z    <= z0;
      flip <= flip_in;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - da;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + da;
      end
    end
  end

  assign res.done  = done;
  assign res.cos_v = flip ? -x : x;
  assign res.sin_v = flip ? -y : y;

endmodule

[hw/rtl/lidar_scan_occupancy_marker.sv]
// Top level of the lidar scan occupancy marker: sequencer, registers, grid store.
//
// Each input word is either a range sample (one ray of a scan) or a read of one grid
// cell, and gives exactly one result word. A sample flagged first_ray starts a new
// scan: the grid reads as empty and the ray counter restarts at zero. A sample within
// [min_range, max_range] is turned into a hit cell: the ray angle is angle_start plus
// ray number times angle_step, one shared CORDIC unit gives cos and sin, and one
// shared 18x34 multiplier forms ray*angle_step, r*scale, the two trig products (each
// in two halves) and the row*GRID_WIDTH index. Hits off the grid report "outside".
// An accepted sample runs through the 16 CORDIC iterations and 7 multiplier passes.
// The block takes one word at a time (sample_stall high while busy); a finished
// result waits in the output register and does not hold up the next word's work.
// Scan clearing uses a per-cell 8-bit scan tag, so a new scan normally costs nothing;
// after reset, and on every 255th new scan, a clearing pass writes all 32768 cells, one
// per cycle, during which sample_stall stays high. Configuration writes
// are taken at any time but must only be made while the block is idle.
module lidar_scan_occupancy_marker import lsom_pkg::*; #(
  parameter int GRID_WIDTH  = 256,
  parameter int GRID_HEIGHT = 128
) (
  input  logic          clk,
  input  logic          rst,
  // configuration port
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  // input words
  input  logic          sample_valid,
  output logic          sample_stall,
  input  logic          cmd,
  input  logic          first_ray,
  input  logic [15:0]   range_sample,
  input  logic [14:0]   read_address,
  // result words
  output logic          result_valid,
  input  logic          result_stall,
  output logic [14:0]   cell_index,
  output logic          occupied,
  output logic [1:0]    status
);

  localparam logic signed [CW-1:0]   HALF_W = CW'(GRID_WIDTH / 2);
  localparam logic signed [CW-1:0]   GW     = CW'(GRID_WIDTH);
  localparam logic signed [CW-1:0]   GH     = CW'(GRID_HEIGHT);
  localparam int                     SUM_W  = MP_W + 16;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_THETA, S_ANGLE, S_PLATCH, S_CORDIC,
    S_SHI, S_SLO, S_CHI, S_CLO, S_CEND, S_BOUND, S_IDX, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] min_range, max_range, angle_start, angle_step, cells_per_m;

  // sequencer registers
  logic [15:0]             ray;
  logic [EPOCH_W-1:0]      epoch;
  logic [ADDR_W-1:0]       clr_cnt;
  logic                    clr_resume;
  logic [15:0]             r_q;
  logic [31:0]             p;
  logic signed [MP_W-1:0]  acc;
  logic signed [CW-1:0]    col_q, row_q;
  logic [ADDR_W-1:0]       res_index;
  logic                    res_occ;
  status_t                 res_status;

  // datapath wiring
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  prod;
  logic [15:0]             theta;
  logic                    in_range;
  logic                    cordic_start;
  cordic_res_t             trig;
  logic signed [SUM_W-1:0] wsum;
  logic signed [CW-1:0]    cell_raw;
  logic signed [CW-1:0]    col_c;
  logic                    off_grid;
  logic [25:0]             idx;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [EPOCH_W-1:0]      ram_wdata;
  logic [EPOCH_W-1:0]      ram_rdata;
  logic                    take;
  logic                    wr_cfg;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range   <= 16'd0;
      max_range   <= 16'hFFFF;
      angle_start <= 16'hC000;
      angle_step  <= 16'd182;
      cells_per_m <= 16'd2560;
    end else if (wr_cfg) begin
      case (paddr[4:2])
        REG_RANGE_MIN:   min_range   <= pwdata[15:0];
        REG_RANGE_MAX:   max_range   <= pwdata[15:0];
        REG_ANGLE_START: angle_start <= pwdata[15:0];
        REG_ANGLE_STEP:  angle_step  <= pwdata[15:0];
        REG_CELLS_PER_M: cells_per_m <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RANGE_MIN:   prdata = {16'b0, min_range};
      REG_RANGE_MAX:   prdata = {16'b0, max_range};
      REG_ANGLE_START: prdata = {16'b0, angle_start};
      REG_ANGLE_STEP:  prdata = {16'b0, angle_step};
      REG_CELLS_PER_M: prdata = {16'b0, cells_per_m};
      default:         prdata = '0;
    endcase
  end

  // ---------------- shared units ----------------
  assign sample_stall = (state != S_IDLE);
  assign take         = sample_valid && !sample_stall;

  // Operand select for the one multiplier; the product is back in the following cycle.
  always_comb begin
    case (state)
      S_THETA: begin
        mul_a = $signed({2'b0, ray});
        mul_b = $signed({18'b0, angle_step});
      end
      S_ANGLE: begin
        mul_a = $signed({2'b0, r_q});
        mul_b = $signed({18'b0, cells_per_m});
      end
      S_SHI: begin
        mul_a = $signed({2'b0, p[31:16]});
        mul_b = MB_W'(trig.sin_v);
      end
      S_SLO: begin
        mul_a = $signed({2'b0, p[15:0]});
        mul_b = MB_W'(trig.sin_v);
      end
      S_CHI: begin
        mul_a = $signed({2'b0, p[31:16]});
        mul_b = MB_W'(trig.cos_v);
      end
      S_CLO: begin
        mul_a = $signed({2'b0, p[15:0]});
        mul_b = MB_W'(trig.cos_v);
      end
      S_BOUND: begin
        mul_a = $signed({1'b0, row_q[MA_W-2:0]});
        mul_b = MB_W'(GW);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lsom_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Ray angle wraps mod one turn.
  assign theta        = angle_start + prod[15:0];
  assign in_range     = (r_q >= min_range) && (r_q <= max_range);
  assign cordic_start = (state == S_ANGLE) && in_range;

  lsom_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .theta (theta),
    .res   (trig)
  );

  // p*trig = (p_hi*trig << 16) + p_lo*trig, then floor to whole cells (46 fraction bits).
  assign wsum     = ($signed({{16{acc[MP_W-1]}}, acc}) <<< 16)
                  + $signed({{16{prod[MP_W-1]}}, prod});
  assign cell_raw = CW'(wsum >>> 46);

  assign col_c    = col_q + HALF_W;
  assign off_grid = (col_c < 0) || (col_c >= GW) || (row_q < 0) || (row_q >= GH);
  assign idx      = prod[25:0] + 26'(col_q[CW-2:0]);

  // Grid store holds the scan tag of the last mark; a cell is set when it matches.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_IDX && idx < 26'(CELL_STORE)) begin
      ram_we    = 1'b1;
      ram_waddr = idx[ADDR_W-1:0];
      ram_wdata = epoch;
    end
  end

  lsom_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (CELL_STORE)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (read_address),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      clr_resume   <= 1'b0;
      epoch        <= EPOCH_W'(1);
      ray          <= '0;
      result_valid <= 1'b0;
    end else begin
      // the hand-off state reloads the output register itself
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            state <= clr_resume ? S_THETA : S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            r_q <= range_sample;
            if (cmd == CMD_READ) begin
              res_index <= read_address;
              state     <= S_READ;
            end else begin
              state <= S_THETA;
              if (first_ray) begin
                ray <= '0;
                if (&epoch) begin
                  // tags about to wrap: wipe the store first
                  epoch      <= EPOCH_W'(1);
                  clr_cnt    <= '0;
                  clr_resume <= 1'b1;
                  state      <= S_CLEAR;
                end else begin
                  epoch <= epoch + 1'b1;
                end
              end
            end
          end
        end
        S_READ: begin
          res_occ    <= (ram_rdata == epoch);
          res_status <= ST_READ;
          state      <= S_DONE;
        end
        S_THETA: begin
          state <= S_ANGLE;
        end
        S_ANGLE: begin
          ray <= ray + 1'b1;
          if (in_range) begin
            state <= S_PLATCH;
          end else begin
            res_index  <= '0;
            res_occ    <= 1'b0;
            res_status <= ST_REJECT;
            state      <= S_DONE;
          end
        end
        S_PLATCH: begin
          p     <= prod[31:0];
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (trig.done) begin
            state <= S_SHI;
          end
        end
        S_SHI: begin
          state <= S_SLO;
        end
        S_SLO: begin
          acc   <= prod;
          state <= S_CHI;
        end
        S_CHI: begin
          col_q <= cell_raw;
          state <= S_CLO;
        end
        S_CLO: begin
          acc   <= prod;
          state <= S_CEND;
        end
        S_CEND: begin
          row_q <= cell_raw;
          state <= S_BOUND;
        end
        S_BOUND: begin
          col_q <= col_c;
          if (off_grid) begin
            res_index  <= '0;
            res_occ    <= 1'b0;
            res_status <= ST_OUTSIDE;
            state      <= S_DONE;
          end else begin
            state <= S_IDX;
          end
        end
        S_IDX: begin
          if (idx < 26'(CELL_STORE)) begin
            res_index  <= idx[ADDR_W-1:0];
            res_occ    <= 1'b1;
            res_status <= ST_MARK;
          end else begin
            res_index  <= '0;
            res_occ    <= 1'b0;
            res_status <= ST_OUTSIDE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            cell_index   <= res_index;
            occupied     <= res_occ;
            status       <= res_status;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  // Grid is written only by the clearing pass or a mark.
  a_grid_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_IDX))
    else $error("grid written outside clear or mark");

  // Tag zero is reserved for cleared cells.
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("scan tag is zero");

  // Only a mark, or a read, may report a set cell.
  a_occ_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_READ) |-> (occupied == (status == ST_MARK)))
    else $error("occupied bit does not match status");

  // A new result is only loaded from the hand-off state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside hand-off");

endmodule
